### hdl/boxf_pkg.sv
// shared types and constants for the 3x3 box mean filter
`default_nettype none

package boxf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int ROW_WIDTH_W = 11;
    localparam int ROW_CNT_W   = 2;
    localparam int COL_SUM_W   = 10;  // three pixels
    localparam int SUM_W       = 12;  // nine pixels
    localparam int RECIP_W     = 12;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [ROW_WIDTH_W-1:0] RESET_ROW_WIDTH = 11'd642;
    localparam int                     MIN_ROW_WIDTH   = 3;

    // row counter saturates once two rows are buffered
    localparam logic [ROW_CNT_W-1:0] ROWS_FULL = 2'd2;

    // divide by 9: ceil(2^15 / 9), exact for sums below 2^15
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 12'd3641;
    localparam int                 DIV9_SHIFT = 15;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mean;
        logic               row_end;
    } mean_out_t;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] bot;
    } window_col_t;

endpackage

`default_nettype wire

### hdl/box_filter_3x3_mean.sv
// top level of the 3x3 box mean filter over a raster pixel stream
// an accepted pixel passes the line buffer, window, sum and output registers before its result is valid
// throughput: one pixel per cycle with no bubbles while the output register is empty or taken
// stages: line buffer read, window shift, nine-pixel sum, reciprocal multiply into the output
// reset (aresetn low, synchronous): clears counters, valids and row_width (642);
//   line buffers and the window keep their contents
`default_nettype none

module box_filter_3x3_mean
    import boxf_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // pixel transactions in
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire pixel_in_t              s_data,
    // mean transactions out
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output mean_out_t                   m_data,
    // row width register
    input  wire logic                   cfg_we,
    input  wire logic [ROW_WIDTH_W-1:0] cfg_wdata
);

    localparam int ADDR_W  = $clog2(MAX_ROW_WIDTH);
    localparam int LIMIT_W = ($clog2(MAX_ROW_WIDTH + 1) > ROW_WIDTH_W)
                           ? $clog2(MAX_ROW_WIDTH + 1) : ROW_WIDTH_W;
    // one spare bit so that col + 1 never wraps
    localparam int CMP_W   = LIMIT_W + 1;

    localparam logic [CMP_W-1:0] MAX_WIDTH = CMP_W'(MAX_ROW_WIDTH);
    localparam logic [CMP_W-1:0] MIN_WIDTH = CMP_W'(MIN_ROW_WIDTH);

    // ------------------------------------------------------------------
    // config register and frame counters
    // ------------------------------------------------------------------
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [ADDR_W-1:0]      column_count_reg, column_count_next;
    logic [ROW_CNT_W-1:0]   row_count_reg, row_count_next;

    // whole pipeline advances together; the output register decouples the sides
    logic pipe_en;
    logic accept;

    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;
    assign accept  = s_valid && pipe_en;

    // ------------------------------------------------------------------
    // address stage: position of the incoming pixel in the frame
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]     width_eff;
    logic [ADDR_W-1:0]    count_cur;
    logic [ROW_CNT_W-1:0] rows_cur;
    logic [ADDR_W-1:0]    col;
    logic                 col_last;
    logic                 col_produce;

    always_comb begin
        // clamp width to the supported range
        width_eff = CMP_W'(row_width_reg);
        if (width_eff < MIN_WIDTH) begin
            width_eff = MIN_WIDTH;
        end else if (width_eff > MAX_WIDTH) begin
            width_eff = MAX_WIDTH;
        end

        // frame start clears the counters before this pixel is placed
        count_cur = s_data.frame_start ? '0 : column_count_reg;
        rows_cur  = s_data.frame_start ? '0 : row_count_reg;

        // a narrowed width makes an overrun column the last of its row
        if (CMP_W'(count_cur) >= width_eff) begin
            col = ADDR_W'(width_eff - CMP_W'(1));
        end else begin
            col = count_cur;
        end
        col_last    = (CMP_W'(col) + CMP_W'(1)) >= width_eff;
        col_produce = (rows_cur == ROWS_FULL) && (col >= ADDR_W'(2));

        if (col_last) begin
            column_count_next = '0;
            row_count_next    = (rows_cur == ROWS_FULL) ? rows_cur
                                                        : rows_cur + ROW_CNT_W'(1);
        end else begin
            column_count_next = col + ADDR_W'(1);
            row_count_next    = rows_cur;
        end
    end

    // ------------------------------------------------------------------
    // line buffer stage registers
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic               b_produce_reg;
    logic               b_last_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic [PIXEL_W-1:0] b_px_reg;
    logic               b_fwd_reg;
    logic [PIXEL_W-1:0] b_fwd_top_reg;
    logic [PIXEL_W-1:0] b_fwd_mid_reg;

    logic [PIXEL_W-1:0] ram_top_q;
    logic [PIXEL_W-1:0] ram_mid_q;
    logic [PIXEL_W-1:0] b_top;
    logic [PIXEL_W-1:0] b_mid;
    logic               b_write;

    // the previous pixel writes its column in the same cycle that this one reads it
    logic               fwd_next;

    assign b_top    = b_fwd_reg ? b_fwd_top_reg : ram_top_q;
    assign b_mid    = b_fwd_reg ? b_fwd_mid_reg : ram_mid_q;
    assign b_write  = pipe_en && b_valid_reg;
    assign fwd_next = b_valid_reg && (b_addr_reg == col);

    // line_two_above takes the old middle row, line_above the new pixel
    boxf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_line_two_above (
        .aclk  (aclk),
        .we    (b_write),
        .waddr (b_addr_reg),
        .wdata (b_mid),
        .re    (pipe_en),
        .raddr (col),
        .rdata (ram_top_q)
    );

    boxf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_line_above (
        .aclk  (aclk),
        .we    (b_write),
        .waddr (b_addr_reg),
        .wdata (b_px_reg),
        .re    (pipe_en),
        .raddr (col),
        .rdata (ram_mid_q)
    );

    // ------------------------------------------------------------------
    // window: three column cells, newest column first
    // ------------------------------------------------------------------
    window_col_t          new_col;
    window_col_t          col_one_back;
    window_col_t          col_two_back;
    logic [COL_SUM_W-1:0] sum_cur;
    logic [COL_SUM_W-1:0] sum_one_back;
    logic [COL_SUM_W-1:0] sum_two_back;

    assign new_col.top = b_top;
    assign new_col.mid = b_mid;
    assign new_col.bot = b_px_reg;

    boxf_cell u_cell_cur (
        .aclk     (aclk),
        .shift_en (b_write),
        .col_in   (new_col),
        .col_out  (col_one_back),
        .col_sum  (sum_cur)
    );

    boxf_cell u_cell_one_back (
        .aclk     (aclk),
        .shift_en (b_write),
        .col_in   (col_one_back),
        .col_out  (col_two_back),
        .col_sum  (sum_one_back)
    );

    boxf_cell u_cell_two_back (
        .aclk     (aclk),
        .shift_en (b_write),
        .col_in   (col_two_back),
        .col_out  (),
        .col_sum  (sum_two_back)
    );

    // ------------------------------------------------------------------
    // sum and divide stages
    // ------------------------------------------------------------------
    logic               c_valid_reg;
    logic               c_last_reg;
    logic               d_valid_reg;
    logic               d_last_reg;
    logic [SUM_W-1:0]   d_sum_reg;
    logic [SUM_W-1:0]   d_sum_next;
    logic [PROD_W-1:0]  div_prod;
    mean_out_t          m_data_reg;
    logic               m_valid_reg;

    assign d_sum_next = SUM_W'(sum_cur) + SUM_W'(sum_one_back) + SUM_W'(sum_two_back);
    // sum / 9 by reciprocal multiply
    assign div_prod   = PROD_W'(d_sum_reg) * PROD_W'(DIV9_RECIP);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= RESET_ROW_WIDTH;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                row_width_reg <= cfg_wdata;
            end
            if (accept) begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
            end
            if (pipe_en) begin
                b_valid_reg <= accept;
                c_valid_reg <= b_valid_reg && b_produce_reg;
                d_valid_reg <= c_valid_reg;
                m_valid_reg <= d_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_produce_reg   <= col_produce;
            b_last_reg      <= col_last;
            b_addr_reg      <= col;
            b_px_reg        <= s_data.pixel;
            b_fwd_reg       <= fwd_next;
            b_fwd_top_reg   <= b_mid;
            b_fwd_mid_reg   <= b_px_reg;
            c_last_reg      <= b_last_reg;
            d_last_reg      <= c_last_reg;
            d_sum_reg       <= d_sum_next;
            m_data_reg.mean    <= div_prod[DIV9_SHIFT +: PIXEL_W];
            m_data_reg.row_end <= d_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### hdl/boxf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module boxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/boxf_cell.sv
// window cell: holds one column of the 3x3 window and its column sum
`default_nettype none

module boxf_cell
    import boxf_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          shift_en,
    input  wire window_col_t   col_in,
    output window_col_t        col_out,
    output logic [COL_SUM_W-1:0] col_sum
);

    window_col_t            col_reg;
    logic [COL_SUM_W-1:0]   sum_reg;
    logic [COL_SUM_W-1:0]   sum_next;

    assign sum_next = COL_SUM_W'(col_in.top) + COL_SUM_W'(col_in.mid)
                    + COL_SUM_W'(col_in.bot);

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

`default_nettype wire

### hdl/boxf_checker.sv
// port-level checks for the 3x3 box mean filter, bound to the top level
`default_nettype none

module boxf_checker
    import boxf_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire mean_out_t m_data
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty output register never blocks the source
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("source stalled with empty output");

    // the source only waits on a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("source stalled without output back-pressure");

    // a stalled result holds its transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result dropped or changed");

endmodule

bind box_filter_3x3_mean boxf_checker u_boxf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
